FILE: hdl/rnab_pkg.sv
`timescale 1ns / 1ps

package rnab_pkg;

    localparam int MAX_RANKS  = 64;
    localparam int RANK_W     = 7;
    localparam int SRC_W      = 8;
    localparam int ROUND_W    = 32;
    localparam int MAP_W      = MAX_RANKS;
    localparam int BIT_IDX_W  = $clog2(MAX_RANKS);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [RANK_W-1:0] RESP_SAT       = {RANK_W{1'b1}};
    localparam logic [RANK_W-1:0] RANK_TOTAL_RST = RANK_W'(1);
    localparam logic [RANK_W-1:0] MAX_RANKS_V    = RANK_W'(MAX_RANKS);

    // Register index of rank_total (paddr[2]).
    localparam logic REG_RANK_TOTAL = 1'b0;

    localparam logic [1:0] ACT_INITIATE = 2'd0;
    localparam logic [1:0] ACT_PIVOT    = 2'd1;
    localparam logic [1:0] ACT_ACK      = 2'd2;
    localparam logic [1:0] ACT_EPOCH    = 2'd3;

    localparam logic [2:0] KIND_PIVOTS  = 3'd0;
    localparam logic [2:0] KIND_ACKS    = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_NONE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_PIVOT_ROUND = 3'd1;
    localparam logic [2:0] ERR_ACK_ROUND   = 3'd2;
    localparam logic [2:0] ERR_BAD_SENDER  = 3'd3;
    localparam logic [2:0] ERR_DUP_ACK     = 3'd4;
    localparam logic [2:0] ERR_BAD_STATE   = 3'd5;
    localparam logic [2:0] ERR_RESET_RENEG = 3'd6;

    localparam logic [1:0] PCODE_INIT   = 2'd0;
    localparam logic [1:0] PCODE_READY  = 2'd1;
    localparam logic [1:0] PCODE_RENEGO = 2'd2;
    localparam logic [1:0] PCODE_ACK    = 2'd3;

    typedef enum logic [3:0] {
        PH_INIT   = 4'b0001,
        PH_READY  = 4'b0010,
        PH_RENEGO = 4'b0100,
        PH_ACK    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         error_code;
        logic [ROUND_W-1:0] round;
        logic [1:0]         phase;
        logic [1:0]         prev_phase;
        logic               last;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_INIT:   code = PCODE_INIT;
            PH_READY:  code = PCODE_READY;
            PH_RENEGO: code = PCODE_RENEGO;
            PH_ACK:    code = PCODE_ACK;
            default:   code = PCODE_INIT;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/rnab_cfg.sv
`timescale 1ns / 1ps

module rnab_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rnab_pkg::PADDR_W-1:0]  paddr,
    input  logic [rnab_pkg::PDATA_W-1:0]  pwdata,
    output logic [rnab_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [rnab_pkg::RANK_W-1:0]   rank_total
);

    logic [rnab_pkg::RANK_W-1:0] rank_total_reg;
    logic                        sel_rank_total;

    assign sel_rank_total = (paddr[2] == rnab_pkg::REG_RANK_TOTAL);
    assign pready         = 1'b1;
    assign rank_total     = rank_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_total_reg <= rnab_pkg::RANK_TOTAL_RST;
        end
        else if (psel && penable && pwrite && sel_rank_total)
        begin
            rank_total_reg <= pwdata[rnab_pkg::RANK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_rank_total)
        begin
            prdata = rnab_pkg::PDATA_W'(rank_total_reg);
        end
    end

endmodule

FILE: hdl/rnab_core.sv
`timescale 1ns / 1ps

module rnab_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [1:0]                    action,
    input  logic [rnab_pkg::SRC_W-1:0]    sender,
    input  logic [rnab_pkg::ROUND_W-1:0]  msg_round,
    input  logic [rnab_pkg::RANK_W-1:0]   rank_total,
    output rnab_pkg::result_t             res0,
    output rnab_pkg::result_t             res1,
    output logic                          two
);

    rnab_pkg::phase_t                cur_phase_reg,        cur_phase_next;
    rnab_pkg::phase_t                earlier_phase_reg,    earlier_phase_next;
    logic [rnab_pkg::ROUND_W-1:0]    pivot_round_reg,      pivot_round_next;
    logic [rnab_pkg::ROUND_W-1:0]    ack_round_reg,        ack_round_next;
    logic [rnab_pkg::RANK_W-1:0]     responders_reg,       responders_next;
    logic [rnab_pkg::MAP_W-1:0]      acked_now_reg,        acked_now_next;
    logic [rnab_pkg::MAP_W-1:0]      acked_next_reg,       acked_next_next;
    logic [rnab_pkg::RANK_W-1:0]     acked_now_count_reg,  acked_now_count_next;
    logic [rnab_pkg::RANK_W-1:0]     acked_next_count_reg, acked_next_count_next;

    logic [rnab_pkg::RANK_W-1:0]     n_eff;
    logic                            bad_sender;
    logic                            pivot_begin;
    logic [rnab_pkg::RANK_W-1:0]     resp_base;
    logic [rnab_pkg::RANK_W-1:0]     resp_inc;
    logic                            pivot_done;
    logic                            ack_is_next;
    logic                            ack_is_now;
    logic [rnab_pkg::MAP_W-1:0]      ack_bit;
    logic [rnab_pkg::RANK_W:0]       now_cnt;
    logic                            ack_complete;
    logic [rnab_pkg::MAP_W-1:0]      next_map_upd;
    logic [rnab_pkg::RANK_W-1:0]     next_cnt_upd;
    logic                            is_error;
    logic [2:0]                      err;
    logic                            two_c;

    assign n_eff = (rank_total > rnab_pkg::MAX_RANKS_V) ? rnab_pkg::MAX_RANKS_V : rank_total;
    assign bad_sender = (sender >= rnab_pkg::SRC_W'(n_eff));

    assign pivot_begin = (cur_phase_reg != rnab_pkg::PH_RENEGO);
    assign resp_base   = pivot_begin ? '0 : responders_reg;
    assign resp_inc    = (resp_base == rnab_pkg::RESP_SAT) ? resp_base
                                                           : resp_base + 1'b1;
    assign pivot_done  = (resp_inc >= n_eff);

    assign ack_is_next  = (msg_round == ack_round_reg + 1'b1);
    assign ack_is_now   = (msg_round == ack_round_reg);
    assign ack_bit      = rnab_pkg::MAP_W'(1) << sender[rnab_pkg::BIT_IDX_W-1:0];
    // The current-round count grows only for an ack of the current round.
    assign now_cnt      = ack_is_next ? {1'b0, acked_now_count_reg}
                                      : {1'b0, acked_now_count_reg} + 1'b1;
    assign ack_complete = (now_cnt >= {1'b0, n_eff});
    assign next_map_upd = ack_is_next ? (acked_next_reg | ack_bit) : acked_next_reg;
    assign next_cnt_upd = ack_is_next ? acked_next_count_reg + 1'b1
                                      : acked_next_count_reg;

    always_comb
    begin
        cur_phase_next        = cur_phase_reg;
        earlier_phase_next    = earlier_phase_reg;
        pivot_round_next      = pivot_round_reg;
        ack_round_next        = ack_round_reg;
        responders_next       = responders_reg;
        acked_now_next        = acked_now_reg;
        acked_next_next       = acked_next_reg;
        acked_now_count_next  = acked_now_count_reg;
        acked_next_count_next = acked_next_count_reg;
        is_error              = 1'b0;
        err                   = rnab_pkg::ERR_NONE;
        two_c                 = 1'b0;
        res0                  = '0;
        res1                  = '0;
        res0.kind             = rnab_pkg::KIND_NONE;
        res1.kind             = rnab_pkg::KIND_NONE;

        case (action)
            rnab_pkg::ACT_INITIATE:
            begin
                if (cur_phase_reg == rnab_pkg::PH_INIT || cur_phase_reg == rnab_pkg::PH_READY)
                begin
                    earlier_phase_next = cur_phase_reg;
                    cur_phase_next     = rnab_pkg::PH_RENEGO;
                    responders_next    = '0;
                    res0.kind          = rnab_pkg::KIND_PIVOTS;
                    res0.round         = pivot_round_reg;
                end
            end
            rnab_pkg::ACT_PIVOT:
            begin
                if (msg_round != pivot_round_reg)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_PIVOT_ROUND;
                end
                else if (bad_sender)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_BAD_SENDER;
                end
                else
                begin
                    responders_next = resp_inc;
                    if (pivot_begin)
                    begin
                        earlier_phase_next = cur_phase_reg;
                        cur_phase_next     = rnab_pkg::PH_RENEGO;
                        res0.kind          = rnab_pkg::KIND_PIVOTS;
                        res0.round         = pivot_round_reg;
                    end
                    if (pivot_done)
                    begin
                        pivot_round_next   = pivot_round_reg + 1'b1;
                        earlier_phase_next = rnab_pkg::PH_RENEGO;
                        cur_phase_next     = rnab_pkg::PH_ACK;
                        if (pivot_begin)
                        begin
                            two_c      = 1'b1;
                            res1.kind  = rnab_pkg::KIND_ACKS;
                            res1.round = ack_round_reg;
                        end
                        else
                        begin
                            res0.kind  = rnab_pkg::KIND_ACKS;
                            res0.round = ack_round_reg;
                        end
                    end
                end
            end
            rnab_pkg::ACT_ACK:
            begin
                if (!ack_is_now && !ack_is_next)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_ACK_ROUND;
                end
                else if (bad_sender)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_BAD_SENDER;
                end
                else if (ack_is_next ? |(acked_next_reg & ack_bit)
                                     : |(acked_now_reg & ack_bit))
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_DUP_ACK;
                end
                else if (ack_complete && cur_phase_reg != rnab_pkg::PH_ACK
                         && cur_phase_reg != rnab_pkg::PH_RENEGO)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_BAD_STATE;
                end
                else if (ack_complete)
                begin
                    // Barrier done: the next-round map becomes the current one.
                    acked_now_next        = next_map_upd;
                    acked_now_count_next  = next_cnt_upd;
                    acked_next_next       = '0;
                    acked_next_count_next = '0;
                    ack_round_next        = ack_round_reg + 1'b1;
                    if (cur_phase_reg == rnab_pkg::PH_ACK)
                    begin
                        earlier_phase_next = cur_phase_reg;
                        cur_phase_next     = rnab_pkg::PH_READY;
                        res0.kind          = rnab_pkg::KIND_RELEASE;
                    end
                end
                else if (ack_is_next)
                begin
                    acked_next_next       = next_map_upd;
                    acked_next_count_next = next_cnt_upd;
                end
                else
                begin
                    acked_now_next       = acked_now_reg | ack_bit;
                    acked_now_count_next = now_cnt[rnab_pkg::RANK_W-1:0];
                end
            end
            rnab_pkg::ACT_EPOCH:
            begin
                if (cur_phase_reg == rnab_pkg::PH_RENEGO)
                begin
                    is_error = 1'b1;
                    err      = rnab_pkg::ERR_RESET_RENEG;
                end
                else
                begin
                    cur_phase_next = rnab_pkg::PH_INIT;
                end
            end
            default:
            begin
                is_error = 1'b0;
            end
        endcase

        if (is_error)
        begin
            cur_phase_next        = cur_phase_reg;
            earlier_phase_next    = earlier_phase_reg;
            pivot_round_next      = pivot_round_reg;
            ack_round_next        = ack_round_reg;
            responders_next       = responders_reg;
            acked_now_next        = acked_now_reg;
            acked_next_next       = acked_next_reg;
            acked_now_count_next  = acked_now_count_reg;
            acked_next_count_next = acked_next_count_reg;
            two_c                 = 1'b0;
            res0.kind             = rnab_pkg::KIND_ERROR;
            res0.error_code       = err;
            res0.round            = '0;
        end

        res0.phase      = rnab_pkg::phase_code(cur_phase_next);
        res0.prev_phase = rnab_pkg::phase_code(earlier_phase_next);
        res0.last       = !two_c;
        res1.phase      = res0.phase;
        res1.prev_phase = res0.prev_phase;
        res1.last       = 1'b1;
    end

    assign two = two_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase_reg        <= rnab_pkg::PH_INIT;
            earlier_phase_reg    <= rnab_pkg::PH_INIT;
            pivot_round_reg      <= '0;
            ack_round_reg        <= '0;
            responders_reg       <= '0;
            acked_now_reg        <= '0;
            acked_next_reg       <= '0;
            acked_now_count_reg  <= '0;
            acked_next_count_reg <= '0;
        end
        else if (step)
        begin
            cur_phase_reg        <= cur_phase_next;
            earlier_phase_reg    <= earlier_phase_next;
            pivot_round_reg      <= pivot_round_next;
            ack_round_reg        <= ack_round_next;
            responders_reg       <= responders_next;
            acked_now_reg        <= acked_now_next;
            acked_next_reg       <= acked_next_next;
            acked_now_count_reg  <= acked_now_count_next;
            acked_next_count_reg <= acked_next_count_next;
        end
    end

endmodule

FILE: hdl/rnab_fifo.sv
`timescale 1ns / 1ps

module rnab_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                push_two,
    input  rnab_pkg::result_t   din0,
    input  rnab_pkg::result_t   din1,
    input  logic                pop,
    output rnab_pkg::result_t   dout,
    output logic                out_valid,
    output logic                room
);

    rnab_pkg::result_t                 mem [rnab_pkg::FIFO_DEPTH];
    logic [rnab_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rnab_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rnab_pkg::FIFO_CNT_W-1:0]   count_reg,  count_next;
    logic [rnab_pkg::FIFO_CNT_W-1:0]   push_cnt;
    logic                              do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign push_cnt  = push ? (push_two ? rnab_pkg::FIFO_CNT_W'(2) : rnab_pkg::FIFO_CNT_W'(1))
                            : '0;
    assign out_valid = (count_reg != '0);
    assign dout      = mem[rd_ptr_reg];
    // Two free slots are needed since one beat can leave two results.
    assign room      = (count_reg <= rnab_pkg::FIFO_CNT_W'(rnab_pkg::FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + push_cnt[rnab_pkg::FIFO_PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + rnab_pkg::FIFO_PTR_W'(do_pop);
    assign count_next  = count_reg + push_cnt - rnab_pkg::FIFO_CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din0;
            if (push_two)
            begin
                mem[wr_ptr_reg + 1'b1] <= din1;
            end
        end
    end

endmodule

FILE: hdl/range_negotiation_ack_barrier_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid / in_ready      action, sender, msg_round
// out       out_valid / out_ready    kind, error_code, round, phase, prev_phase, last
// cfg       APB, pready tied high    paddr, pwdata, prdata (rank_total at 0x0)
//
// One event is taken per cycle unless the input stalls. It is held in the input
// register, where it is resolved against the barrier state, and its results enter a
// four-beat output queue at the edge on which the event leaves that register. A
// pivot that both opens and closes a round gives two result beats. The input stalls
// only while an event is held and the queue has fewer than two free slots. Reset
// clears all phase, round, bitmap and queue state; rank_total resets to one.

module range_negotiation_ack_barrier_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [rnab_pkg::SRC_W-1:0]    sender,
    input  logic [rnab_pkg::ROUND_W-1:0]  msg_round,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    kind,
    output logic [2:0]                    error_code,
    output logic [rnab_pkg::ROUND_W-1:0]  round,
    output logic [1:0]                    phase,
    output logic [1:0]                    prev_phase,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rnab_pkg::PADDR_W-1:0]  paddr,
    input  logic [rnab_pkg::PDATA_W-1:0]  pwdata,
    output logic [rnab_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic                          in_valid_reg;
    logic [1:0]                    action_reg;
    logic [rnab_pkg::SRC_W-1:0]    sender_reg;
    logic [rnab_pkg::ROUND_W-1:0]  msg_round_reg;
    logic [rnab_pkg::RANK_W-1:0]   rank_total;
    logic                          step;
    logic                          room;
    logic                          two;
    rnab_pkg::result_t             res0;
    rnab_pkg::result_t             res1;
    rnab_pkg::result_t             head;

    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg    <= action;
            sender_reg    <= sender;
            msg_round_reg <= msg_round;
        end
    end

    rnab_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .rank_total (rank_total)
    );

    rnab_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .action     (action_reg),
        .sender     (sender_reg),
        .msg_round  (msg_round_reg),
        .rank_total (rank_total),
        .res0       (res0),
        .res1       (res1),
        .two        (two)
    );

    rnab_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_two  (two),
        .din0      (res0),
        .din1      (res1),
        .pop       (out_ready),
        .dout      (head),
        .out_valid (out_valid),
        .room      (room)
    );

    assign kind       = head.kind;
    assign error_code = head.error_code;
    assign round      = head.round;
    assign phase      = head.phase;
    assign prev_phase = head.prev_phase;
    assign last       = head.last;

endmodule

FILE: tb/sv/tb_range_negotiation_ack_barrier_unit.sv
`timescale 1ns / 1ps

module tb_range_negotiation_ack_barrier_unit;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int RANDOM_PER_SETTING = 110;
    localparam int NUM_SETTINGS       = 10;

    localparam logic [rnab_pkg::PADDR_W-1:0] RANK_TOTAL_ADDR =
        {rnab_pkg::REG_RANK_TOTAL, 2'b00};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [1:0]                     action;
    logic [rnab_pkg::SRC_W-1:0]     sender;
    logic [rnab_pkg::ROUND_W-1:0]   msg_round;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [2:0]                     kind;
    logic [2:0]                     error_code;
    logic [rnab_pkg::ROUND_W-1:0]   round;
    logic [1:0]                     phase;
    logic [1:0]                     prev_phase;
    logic                           last;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rnab_pkg::PADDR_W-1:0]   paddr;
    logic [rnab_pkg::PDATA_W-1:0]   pwdata;
    logic [rnab_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Barrier state as the testbench predicts it.
    logic [rnab_pkg::RANK_W-1:0]    m_rank_total;
    logic [1:0]                     m_phase;
    logic [1:0]                     m_prev;
    logic [rnab_pkg::ROUND_W-1:0]   m_pivot_round;
    logic [rnab_pkg::ROUND_W-1:0]   m_ack_round;
    logic [rnab_pkg::RANK_W-1:0]    m_responders;
    logic [rnab_pkg::MAP_W-1:0]     m_acked_now;
    logic [rnab_pkg::MAP_W-1:0]     m_acked_next;
    logic [rnab_pkg::RANK_W-1:0]    m_now_cnt;
    logic [rnab_pkg::RANK_W-1:0]    m_next_cnt;

    rnab_pkg::result_t expected_beats[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      stall_pct = 0;
    int      hold_low = 0;

    range_negotiation_ack_barrier_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sender     (sender),
        .msg_round  (msg_round),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .error_code (error_code),
        .round      (round),
        .phase      (phase),
        .prev_phase (prev_phase),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("range_negotiation_ack_barrier_unit: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus an occasional long hold while stalling is on.
    always @(posedge clk)
    begin
        if (hold_low > 0)
        begin
            hold_low <= hold_low - 1;
            out_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(199) == 0)
        begin
            hold_low <= $urandom_range(20, 8);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : beat_check
        rnab_pkg::result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("beat with nothing expected, kind", 32'(kind), 32'd0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (error_code !== want.error_code)
                    report_mismatch("error_code", 32'(error_code), 32'(want.error_code));
                if (round !== want.round)
                    report_mismatch("round", round, want.round);
                if (phase !== want.phase)
                    report_mismatch("phase", 32'(phase), 32'(want.phase));
                if (prev_phase !== want.prev_phase)
                    report_mismatch("prev_phase", 32'(prev_phase), 32'(want.prev_phase));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    function automatic rnab_pkg::result_t beat(input logic [2:0] k, input logic [2:0] err,
                                               input logic [rnab_pkg::ROUND_W-1:0] rnd);
        rnab_pkg::result_t b;
        b = '0;
        b.kind = k;
        b.error_code = err;
        b.round = rnd;
        return b;
    endfunction

    // Works out the result beats of one accepted event and advances the state.
    task automatic barrier_predict(input logic [1:0] act,
                                   input logic [rnab_pkg::SRC_W-1:0] src,
                                   input logic [rnab_pkg::ROUND_W-1:0] rnd);
        rnab_pkg::result_t            beats[$];
        logic [rnab_pkg::RANK_W-1:0]  n;
        logic [rnab_pkg::MAP_W-1:0]   rank_bit;
        logic                         to_next;
        logic                         marked;
        int                           acked;
        n = (m_rank_total < rnab_pkg::MAX_RANKS_V) ? m_rank_total : rnab_pkg::MAX_RANKS_V;
        rank_bit = rnab_pkg::MAP_W'(1) << src[rnab_pkg::BIT_IDX_W-1:0];
        to_next = (rnd == m_ack_round + rnab_pkg::ROUND_W'(1));
        marked = to_next ? ((m_acked_next & rank_bit) != '0)
                         : ((m_acked_now & rank_bit) != '0);
        acked = to_next ? int'(m_now_cnt) : int'(m_now_cnt) + 1;
        case (act)
            rnab_pkg::ACT_INITIATE:
            begin
                if (m_phase == rnab_pkg::PCODE_INIT || m_phase == rnab_pkg::PCODE_READY)
                begin
                    m_prev = m_phase;
                    m_phase = rnab_pkg::PCODE_RENEGO;
                    m_responders = '0;
                    beats = {beats, beat(rnab_pkg::KIND_PIVOTS, rnab_pkg::ERR_NONE,
                                         m_pivot_round)};
                end
                else
                begin
                    beats = {beats, beat(rnab_pkg::KIND_NONE, rnab_pkg::ERR_NONE, '0)};
                end
            end
            rnab_pkg::ACT_PIVOT:
            begin
                if (rnd != m_pivot_round)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_PIVOT_ROUND, '0)};
                else if (src >= n)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_BAD_SENDER, '0)};
                else
                begin
                    // A pivot outside renegotiation opens the round itself.
                    if (m_phase != rnab_pkg::PCODE_RENEGO)
                    begin
                        m_prev = m_phase;
                        m_phase = rnab_pkg::PCODE_RENEGO;
                        m_responders = '0;
                        beats = {beats, beat(rnab_pkg::KIND_PIVOTS, rnab_pkg::ERR_NONE,
                                             m_pivot_round)};
                    end
                    if (m_responders != rnab_pkg::RESP_SAT)
                        m_responders = m_responders + 1'b1;
                    if (m_responders >= n)
                    begin
                        m_pivot_round = m_pivot_round + 1'b1;
                        m_prev = m_phase;
                        m_phase = rnab_pkg::PCODE_ACK;
                        beats = {beats, beat(rnab_pkg::KIND_ACKS, rnab_pkg::ERR_NONE,
                                             m_ack_round)};
                    end
                    else if (beats.size() == 0)
                    begin
                        beats = {beats, beat(rnab_pkg::KIND_NONE, rnab_pkg::ERR_NONE, '0)};
                    end
                end
            end
            rnab_pkg::ACT_ACK:
            begin
                if (rnd != m_ack_round && !to_next)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_ACK_ROUND, '0)};
                else if (src >= n)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_BAD_SENDER, '0)};
                else if (marked)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_DUP_ACK, '0)};
                else if (acked >= n && m_phase != rnab_pkg::PCODE_ACK
                         && m_phase != rnab_pkg::PCODE_RENEGO)
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_BAD_STATE, '0)};
                else
                begin
                    if (to_next)
                    begin
                        m_acked_next = m_acked_next | rank_bit;
                        m_next_cnt = m_next_cnt + 1'b1;
                    end
                    else
                    begin
                        m_acked_now = m_acked_now | rank_bit;
                        m_now_cnt = rnab_pkg::RANK_W'(acked);
                    end
                    // Barrier complete: the next-round map becomes the current one.
                    if (m_now_cnt >= n)
                    begin
                        m_acked_now = m_acked_next;
                        m_acked_next = '0;
                        m_now_cnt = m_next_cnt;
                        m_next_cnt = '0;
                        m_ack_round = m_ack_round + 1'b1;
                        if (m_phase == rnab_pkg::PCODE_ACK)
                        begin
                            m_prev = m_phase;
                            m_phase = rnab_pkg::PCODE_READY;
                            beats = {beats, beat(rnab_pkg::KIND_RELEASE, rnab_pkg::ERR_NONE,
                                                 '0)};
                        end
                    end
                    if (beats.size() == 0)
                        beats = {beats, beat(rnab_pkg::KIND_NONE, rnab_pkg::ERR_NONE, '0)};
                end
            end
            default:
            begin
                if (m_phase == rnab_pkg::PCODE_RENEGO)
                begin
                    beats = {beats, beat(rnab_pkg::KIND_ERROR, rnab_pkg::ERR_RESET_RENEG, '0)};
                end
                else
                begin
                    m_phase = rnab_pkg::PCODE_INIT;
                    beats = {beats, beat(rnab_pkg::KIND_NONE, rnab_pkg::ERR_NONE, '0)};
                end
            end
        endcase
        foreach (beats[i])
        begin
            beats[i].phase = m_phase;
            beats[i].prev_phase = m_prev;
            beats[i].last = (i == beats.size() - 1);
            expected_beats = {expected_beats, beats[i]};
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the beat, valid left high.
    task automatic send_event(input logic [1:0] act, input logic [rnab_pkg::SRC_W-1:0] src,
                              input logic [rnab_pkg::ROUND_W-1:0] rnd);
        in_valid <= 1'b1;
        action <= act;
        sender <= src;
        msg_round <= rnd;
        do @(posedge clk); while (in_ready !== 1'b1);
        barrier_predict(act, src, rnd);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Ends idle, with psel and penable low, so back-to-back accesses never drive twice at one edge.
    task automatic apb_access(input logic wr, input logic [rnab_pkg::PDATA_W-1:0] wdata,
                              output logic [rnab_pkg::PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= RANK_TOTAL_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rank_total(input int value);
        logic [rnab_pkg::PDATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, rnab_pkg::PDATA_W'(value), rd);
        m_rank_total = rnab_pkg::RANK_W'(value);
        apb_access(1'b0, '0, rd);
        if (rd[rnab_pkg::RANK_W-1:0] !== m_rank_total)
            report_mismatch("rank_total readback", rd, 32'(m_rank_total));
    endtask

    // Mostly well-formed traffic for the current phase, with some noise mixed in.
    task automatic choose_event(output logic [1:0] act,
                                output logic [rnab_pkg::SRC_W-1:0] src,
                                output logic [rnab_pkg::ROUND_W-1:0] rnd);
        int                          n;
        int                          r;
        int                          start;
        logic                        to_next;
        logic [rnab_pkg::MAP_W-1:0]  map;
        n = (m_rank_total < rnab_pkg::MAX_RANKS_V) ? int'(m_rank_total)
                                                   : rnab_pkg::MAX_RANKS;
        r = $urandom_range(99);
        act = rnab_pkg::ACT_EPOCH;
        src = rnab_pkg::SRC_W'($urandom_range(255));
        rnd = $urandom;
        if (r < 10 || n == 0)
        begin
            act = 2'($urandom_range(3));
            case ($urandom_range(5))
                0: rnd = m_pivot_round;
                1: rnd = m_pivot_round + 1'b1;
                2: rnd = m_ack_round - 1'b1;
                3: rnd = m_ack_round + 2'd2;
                4: rnd = '1;
                default: rnd = $urandom;
            endcase
            return;
        end
        r = $urandom_range(99);
        case (m_phase)
            rnab_pkg::PCODE_RENEGO:
                act = (r < 75) ? rnab_pkg::ACT_PIVOT : (r < 93) ? rnab_pkg::ACT_ACK :
                      (r < 97) ? rnab_pkg::ACT_INITIATE : rnab_pkg::ACT_EPOCH;
            rnab_pkg::PCODE_ACK:
                act = (r < 90) ? rnab_pkg::ACT_ACK :
                      (r < 95) ? rnab_pkg::ACT_INITIATE : rnab_pkg::ACT_EPOCH;
            default:
                act = (r < 60) ? rnab_pkg::ACT_INITIATE : (r < 80) ? rnab_pkg::ACT_PIVOT :
                      (r < 95) ? rnab_pkg::ACT_ACK : rnab_pkg::ACT_EPOCH;
        endcase
        start = $urandom_range(n - 1);
        src = rnab_pkg::SRC_W'(start);
        if (act == rnab_pkg::ACT_PIVOT)
        begin
            rnd = m_pivot_round;
        end
        else if (act == rnab_pkg::ACT_ACK)
        begin
            to_next = (m_phase == rnab_pkg::PCODE_ACK) ? ($urandom_range(7) == 0)
                                                       : 1'($urandom_range(1));
            rnd = to_next ? m_ack_round + 1'b1 : m_ack_round;
            map = to_next ? m_acked_next : m_acked_now;
            // Prefer a rank that has not acked yet, so that barriers complete.
            for (int k = 0; k < n; k++)
            begin
                if (!map[(start + k) % n])
                begin
                    src = rnab_pkg::SRC_W'((start + k) % n);
                    break;
                end
            end
        end
    endtask

    task automatic test_register_access();
        logic [rnab_pkg::PDATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[rnab_pkg::RANK_W-1:0] !== rnab_pkg::RANK_TOTAL_RST)
            report_mismatch("rank_total after reset", rd, 32'(rnab_pkg::RANK_TOTAL_RST));
        set_rank_total(127);
        set_rank_total(1);
    endtask

    task automatic test_directed_events();
        stall_pct = 40;
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd0);            // barrier completion while idle is refused
        send_event(rnab_pkg::ACT_EPOCH, 8'd0, 32'd0);
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd5);          // wrong pivot round
        send_event(rnab_pkg::ACT_PIVOT, 8'd1, 32'd0);          // sender out of range
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd0);          // opens and closes the round
        send_event(rnab_pkg::ACT_INITIATE, 8'd0, 32'd0);       // ignored while acking
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'hFFFF_FFFF);
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd1);            // early ack for the next round
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd1);
        send_event(rnab_pkg::ACT_ACK, 8'hFF, 32'd0);
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd0);            // completes the barrier and releases
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd1);
        send_event(rnab_pkg::ACT_EPOCH, 8'd0, 32'd0);
        send_event(rnab_pkg::ACT_INITIATE, 8'd0, 32'd0);
        send_event(rnab_pkg::ACT_EPOCH, 8'd0, 32'd0);          // not allowed while renegotiating
        send_event(rnab_pkg::ACT_INITIATE, 8'd0, 32'd0);
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd2);            // barrier done while renegotiating
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd1);
        set_rank_total(0);
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd2);
        send_event(rnab_pkg::ACT_ACK, 8'd0, 32'd2);
        set_rank_total(3);
        send_event(rnab_pkg::ACT_EPOCH, 8'd0, 32'd0);
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd2);
        send_event(rnab_pkg::ACT_PIVOT, 8'd0, 32'd2);          // repeated sender still counts
        // Lowering the rank count mid-round lets the next pivot close it.
        set_rank_total(2);
        send_event(rnab_pkg::ACT_PIVOT, 8'd1, 32'd2);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int                            settings[NUM_SETTINGS];
        int                            burst;
        int                            gap_max;
        logic [1:0]                    act;
        logic [rnab_pkg::SRC_W-1:0]    src;
        logic [rnab_pkg::ROUND_W-1:0]  rnd;
        settings = '{1, 2, 4, 64, 7, 127, 0, 3, 16, 1};
        settings[NUM_SETTINGS-1] = $urandom_range(64, 1);
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            set_rank_total(settings[p]);
            stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 65;
            gap_max = (p % 4 == 0) ? 0 : 2 * (p % 4) + 1;
            burst = $urandom_range(16, 1);
            for (int i = 0; i < RANDOM_PER_SETTING; i++)
            begin
                if (i == RANDOM_PER_SETTING / 2 && p % 2 == 1)
                begin
                    drain_results();
                end
                else if (burst == 0)
                begin
                    burst = $urandom_range(16, 1);
                    if (gap_max != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
                    end
                end
                choose_event(act, src, rnd);
                send_event(act, src, rnd);
                burst--;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= rnab_pkg::ACT_INITIATE;
        sender <= '0;
        msg_round <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        m_rank_total = rnab_pkg::RANK_TOTAL_RST;
        m_phase = rnab_pkg::PCODE_INIT;
        m_prev = rnab_pkg::PCODE_INIT;
        m_pivot_round = '0;
        m_ack_round = '0;
        m_responders = '0;
        m_acked_now = '0;
        m_acked_next = '0;
        m_now_cnt = '0;
        m_next_cnt = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_events();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("range_negotiation_ack_barrier_unit: match");
        else
            $display("range_negotiation_ack_barrier_unit: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hdl/rnab_pkg.sv
hdl/rnab_cfg.sv
hdl/rnab_core.sv
hdl/rnab_fifo.sv
hdl/range_negotiation_ack_barrier_unit.sv
tb/sv/tb_range_negotiation_ack_barrier_unit.sv
